/* src/crm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crm_pkg
// Shared widths, operation codes and controller/datapath interface types for
// the complex rotator mixer.
// ----------------------------------------------------------------------------
package crm_pkg;

   // phasor fixed point format
   localparam int FRAC_BITS = 30;
   localparam int PHASE_W   = 32;
   localparam int SAMPLE_W  = 16;
   localparam int OUT_W     = 17;
   localparam int PROD_W    = 2 * PHASE_W;
   localparam int ACC_W     = PROD_W + 2;

   // renormalisation: square root of a PROD_W-bit magnitude, then long division
   localparam int SQ_W       = PROD_W;
   localparam int SQRT_ITERS = SQ_W / 2;
   localparam int DIV_W      = PHASE_W + FRAC_BITS;
   localparam int ROT_STEPS  = 10;
   localparam int CNT_W      = $clog2(DIV_W);

   localparam logic signed [PHASE_W-1:0] ONE_Q     = PHASE_W'(64'd1 << FRAC_BITS);
   localparam logic signed [PHASE_W-1:0] NEG_ONE_Q = -ONE_Q;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_ROTATE_EN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_COS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_SIN  = 2'd2;

   // multiplier operand pairs
   localparam int MUL_OP_W = 4;
   localparam logic [MUL_OP_W-1:0] MUL_NONE = 4'd0;
   localparam logic [MUL_OP_W-1:0] MUL_RC   = 4'd1;
   localparam logic [MUL_OP_W-1:0] MUL_QS   = 4'd2;
   localparam logic [MUL_OP_W-1:0] MUL_QC   = 4'd3;
   localparam logic [MUL_OP_W-1:0] MUL_RS   = 4'd4;
   localparam logic [MUL_OP_W-1:0] MUL_CSC  = 4'd5;
   localparam logic [MUL_OP_W-1:0] MUL_SSS  = 4'd6;
   localparam logic [MUL_OP_W-1:0] MUL_SSC  = 4'd7;
   localparam logic [MUL_OP_W-1:0] MUL_CSS  = 4'd8;
   localparam logic [MUL_OP_W-1:0] MUL_CC   = 4'd9;
   localparam logic [MUL_OP_W-1:0] MUL_SS   = 4'd10;

   // accumulator operations
   localparam int ACC_OP_W = 2;
   localparam logic [ACC_OP_W-1:0] ACC_NONE = 2'd0;
   localparam logic [ACC_OP_W-1:0] ACC_LOAD = 2'd1;
   localparam logic [ACC_OP_W-1:0] ACC_ADD  = 2'd2;
   localparam logic [ACC_OP_W-1:0] ACC_SUB  = 2'd3;

   // rotation write-back operations
   localparam int WB_OP_W = 3;
   localparam logic [WB_OP_W-1:0] WB_NONE    = 3'd0;
   localparam logic [WB_OP_W-1:0] WB_OUT_I   = 3'd1;
   localparam logic [WB_OP_W-1:0] WB_OUT_Q   = 3'd2;
   localparam logic [WB_OP_W-1:0] WB_NEW_C   = 3'd3;
   localparam logic [WB_OP_W-1:0] WB_PHASOR  = 3'd4;

   // renormalisation operations
   localparam int RN_OP_W = 4;
   localparam logic [RN_OP_W-1:0] RN_NONE       = 4'd0;
   localparam logic [RN_OP_W-1:0] RN_SQRT_INIT  = 4'd1;
   localparam logic [RN_OP_W-1:0] RN_SQRT_STEP  = 4'd2;
   localparam logic [RN_OP_W-1:0] RN_MAG        = 4'd3;
   localparam logic [RN_OP_W-1:0] RN_DIV_INIT_C = 4'd4;
   localparam logic [RN_OP_W-1:0] RN_DIV_INIT_S = 4'd5;
   localparam logic [RN_OP_W-1:0] RN_DIV_STEP   = 4'd6;
   localparam logic [RN_OP_W-1:0] RN_WRITE_C    = 4'd7;
   localparam logic [RN_OP_W-1:0] RN_WRITE_S    = 4'd8;

   typedef struct packed {
      logic                load_req;
      logic [MUL_OP_W-1:0] mul_op;
      logic [ACC_OP_W-1:0] acc_op;
      logic [WB_OP_W-1:0]  wb_op;
      logic [RN_OP_W-1:0]  rn_op;
      logic                publish;
   } crm_cmd_type;

   typedef struct packed {
      logic rotate_en;
      logic last;
      logic m2_zero;
   } crm_status_type;

endpackage
`default_nettype wire

/* src/crm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crm_ctrl
// Sequencer for the mixer: schedules the shared multiplier for rotation and the
// squared magnitude, steps the square root and divider for renormalisation, and
// owns the request and response handshakes.
// ----------------------------------------------------------------------------
module crm_ctrl
   import crm_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire crm_status_type status,
   output crm_cmd_type         cmd
);

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE = 4'd0;
   localparam logic [ST_W-1:0] S_CHK  = 4'd1;
   localparam logic [ST_W-1:0] S_ROT  = 4'd2;
   localparam logic [ST_W-1:0] S_NRM  = 4'd3;
   localparam logic [ST_W-1:0] S_SQRT = 4'd4;
   localparam logic [ST_W-1:0] S_MAG  = 4'd5;
   localparam logic [ST_W-1:0] S_DINC = 4'd6;
   localparam logic [ST_W-1:0] S_DIVC = 4'd7;
   localparam logic [ST_W-1:0] S_WRC  = 4'd8;
   localparam logic [ST_W-1:0] S_DINS = 4'd9;
   localparam logic [ST_W-1:0] S_DIVS = 4'd10;
   localparam logic [ST_W-1:0] S_WRS  = 4'd11;
   localparam logic [ST_W-1:0] S_PUB  = 4'd12;

   logic [ST_W-1:0]  state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cnt_in       = '0;
               state_in     = status.rotate_en ? S_ROT : S_CHK;
            end
         end
         S_CHK: begin
            state_in = status.last ? S_NRM : S_PUB;
         end
         S_ROT: begin
            // each product is registered, then accumulated in the cycle after
            case (cnt_ff)
               CNT_W'(0): cmd.mul_op = MUL_RC;
               CNT_W'(1): begin
                  cmd.mul_op = MUL_QS;
                  cmd.acc_op = ACC_LOAD;
               end
               CNT_W'(2): begin
                  cmd.mul_op = MUL_QC;
                  cmd.acc_op = ACC_SUB;
               end
               CNT_W'(3): begin
                  cmd.mul_op = MUL_RS;
                  cmd.acc_op = ACC_LOAD;
                  cmd.wb_op  = WB_OUT_I;
               end
               CNT_W'(4): begin
                  cmd.mul_op = MUL_CSC;
                  cmd.acc_op = ACC_ADD;
               end
               CNT_W'(5): begin
                  cmd.mul_op = MUL_SSS;
                  cmd.acc_op = ACC_LOAD;
                  cmd.wb_op  = WB_OUT_Q;
               end
               CNT_W'(6): begin
                  cmd.mul_op = MUL_SSC;
                  cmd.acc_op = ACC_SUB;
               end
               CNT_W'(7): begin
                  cmd.mul_op = MUL_CSS;
                  cmd.acc_op = ACC_LOAD;
                  cmd.wb_op  = WB_NEW_C;
               end
               CNT_W'(8): cmd.acc_op = ACC_ADD;
               CNT_W'(9): cmd.wb_op  = WB_PHASOR;
               default: cmd.mul_op = MUL_NONE;
            endcase
            if (cnt_ff == CNT_W'(ROT_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = status.last ? S_NRM : S_PUB;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_NRM: begin
            // squared magnitude into the accumulator
            case (cnt_ff)
               CNT_W'(0): cmd.mul_op = MUL_CC;
               CNT_W'(1): begin
                  cmd.mul_op = MUL_SS;
                  cmd.acc_op = ACC_LOAD;
               end
               CNT_W'(2): cmd.acc_op = ACC_ADD;
               CNT_W'(3): cmd.rn_op  = RN_SQRT_INIT;
               default: cmd.rn_op = RN_NONE;
            endcase
            if (cnt_ff == CNT_W'(3)) begin
               cnt_in   = '0;
               state_in = status.m2_zero ? S_PUB : S_SQRT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SQRT: begin
            cmd.rn_op = RN_SQRT_STEP;
            if (cnt_ff == CNT_W'(SQRT_ITERS - 1)) begin
               cnt_in   = '0;
               state_in = S_MAG;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_MAG: begin
            cmd.rn_op = RN_MAG;
            state_in  = S_DINC;
         end
         S_DINC: begin
            cmd.rn_op = RN_DIV_INIT_C;
            cnt_in    = '0;
            state_in  = S_DIVC;
         end
         S_DIVC: begin
            cmd.rn_op = RN_DIV_STEP;
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               cnt_in   = '0;
               state_in = S_WRC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_WRC: begin
            cmd.rn_op = RN_WRITE_C;
            state_in  = S_DINS;
         end
         S_DINS: begin
            cmd.rn_op = RN_DIV_INIT_S;
            cnt_in    = '0;
            state_in  = S_DIVS;
         end
         S_DIVS: begin
            cmd.rn_op = RN_DIV_STEP;
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               cnt_in   = '0;
               state_in = S_WRS;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_WRS: begin
            cmd.rn_op = RN_WRITE_S;
            state_in  = S_PUB;
         end
         S_PUB: begin
            // hand over once the output register is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* src/crm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crm_datapath
// Configuration and phasor registers, one shared 32x32 multiplier with an
// accumulator, a bit-pair square root, a restoring divider and the output
// register.
// ----------------------------------------------------------------------------
module crm_datapath
   import crm_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [PHASE_W-1:0]         csr_wdata,
   input  wire logic signed [SAMPLE_W-1:0] req_in_i,
   input  wire logic signed [SAMPLE_W-1:0] req_in_q,
   input  wire logic                       req_block_end,
   input  wire crm_cmd_type                cmd,
   output crm_status_type                  status,
   output logic signed [OUT_W-1:0]         rsp_out_i,
   output logic signed [OUT_W-1:0]         rsp_out_q,
   output logic                            rsp_out_last
);

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] x);
      logic fits;
      fits = (&x[ACC_W-1:OUT_W-1]) || !(|x[ACC_W-1:OUT_W-1]);
      if (fits) begin
         return x[OUT_W-1:0];
      end else if (x[ACC_W-1]) begin
         return {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         return {1'b0, {(OUT_W-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [PHASE_W-1:0] sat_phase(input logic signed [ACC_W-1:0] x);
      logic fits;
      fits = (&x[ACC_W-1:PHASE_W-1]) || !(|x[ACC_W-1:PHASE_W-1]);
      if (fits) begin
         return x[PHASE_W-1:0];
      end else if (x[ACC_W-1]) begin
         return {1'b1, {(PHASE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(PHASE_W-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [PHASE_W-1:0] sat_step(input logic signed [PHASE_W-1:0] w);
      if (w > ONE_Q) begin
         return ONE_Q;
      end else if (w < NEG_ONE_Q) begin
         return NEG_ONE_Q;
      end else begin
         return w;
      end
   endfunction

   // configuration and phasor
   logic                      en_ff, en_in;
   logic signed [PHASE_W-1:0] sc_ff, sc_in;
   logic signed [PHASE_W-1:0] ss_ff, ss_in;
   logic signed [PHASE_W-1:0] c_ff, c_in;
   logic signed [PHASE_W-1:0] s_ff, s_in;

   // sample and result staging
   logic signed [SAMPLE_W-1:0] r_ff, q_ff;
   logic                       last_ff;
   logic signed [OUT_W-1:0]    res_i_ff, res_q_ff;
   logic signed [OUT_W-1:0]    out_i_ff, out_q_ff;
   logic                       out_last_ff;

   // multiply-accumulate
   logic signed [PHASE_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod_in, prod_ff;
   logic signed [ACC_W-1:0]   prod_ext, acc_ff, acc_rnd, acc_shr;
   logic signed [PHASE_W-1:0] nc_ff;
   logic signed [PHASE_W-1:0] r_ext, q_ext;

   // square root
   logic [SQ_W-1:0]    sq_rem_ff, sq_root_ff, sq_bit_ff, sq_trial;
   logic [PHASE_W-1:0] mag_value, mag_ff;

   // divider
   logic [DIV_W-1:0]        div_q_ff;
   logic [PHASE_W-1:0]      div_rem_ff;
   logic                    div_neg_ff;
   logic signed [PHASE_W-1:0] div_src;
   logic [PHASE_W-1:0]      div_abs;
   logic [DIV_W-1:0]        div_dvd;
   logic [PHASE_W:0]        div_sh, div_sub;
   logic                    div_ge;
   logic                    q_over_pos, q_over_neg;
   logic signed [PHASE_W-1:0] div_result;

   assign r_ext = {{(PHASE_W-SAMPLE_W){r_ff[SAMPLE_W-1]}}, r_ff};
   assign q_ext = {{(PHASE_W-SAMPLE_W){q_ff[SAMPLE_W-1]}}, q_ff};

   always_comb begin
      case (cmd.mul_op)
         MUL_RC: begin
            mul_a = r_ext;
            mul_b = c_ff;
         end
         MUL_QS: begin
            mul_a = q_ext;
            mul_b = s_ff;
         end
         MUL_QC: begin
            mul_a = q_ext;
            mul_b = c_ff;
         end
         MUL_RS: begin
            mul_a = r_ext;
            mul_b = s_ff;
         end
         MUL_CSC: begin
            mul_a = c_ff;
            mul_b = sc_ff;
         end
         MUL_SSS: begin
            mul_a = s_ff;
            mul_b = ss_ff;
         end
         MUL_SSC: begin
            mul_a = s_ff;
            mul_b = sc_ff;
         end
         MUL_CSS: begin
            mul_a = c_ff;
            mul_b = ss_ff;
         end
         MUL_CC: begin
            mul_a = c_ff;
            mul_b = c_ff;
         end
         MUL_SS: begin
            mul_a = s_ff;
            mul_b = s_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   // round half up, then drop the fraction
   assign acc_rnd = acc_ff + ROUND_HALF;
   assign acc_shr = acc_rnd >>> FRAC_BITS;

   // square root trial and rounded magnitude
   assign sq_trial  = sq_root_ff + sq_bit_ff;
   assign mag_value = sq_root_ff[PHASE_W-1:0] + PHASE_W'(sq_rem_ff > sq_root_ff);

   // divider set-up: |x| * 2^F plus half the divisor
   assign div_src = (cmd.rn_op == RN_DIV_INIT_S) ? s_ff : c_ff;
   assign div_abs = div_src[PHASE_W-1] ? (~div_src + 1'b1) : div_src;
   assign div_dvd = {div_abs, {FRAC_BITS{1'b0}}} + DIV_W'(mag_ff >> 1);

   assign div_sh  = {div_rem_ff, div_q_ff[DIV_W-1]};
   assign div_ge  = div_sh >= {1'b0, mag_ff};
   assign div_sub = div_sh - {1'b0, mag_ff};

   assign q_over_pos = |div_q_ff[DIV_W-1:PHASE_W-1];
   assign q_over_neg = (|div_q_ff[DIV_W-1:PHASE_W])
                     || (div_q_ff[PHASE_W-1] && (|div_q_ff[PHASE_W-2:0]));

   always_comb begin
      if (div_neg_ff) begin
         div_result = q_over_neg ? {1'b1, {(PHASE_W-1){1'b0}}}
                                 : (~div_q_ff[PHASE_W-1:0] + 1'b1);
      end else begin
         div_result = q_over_pos ? {1'b0, {(PHASE_W-1){1'b1}}}
                                 : div_q_ff[PHASE_W-1:0];
      end
   end

   // configuration and phasor next state
   always_comb begin
      en_in = en_ff;
      sc_in = sc_ff;
      ss_in = ss_ff;
      c_in  = c_ff;
      s_in  = s_ff;
      if (cmd.wb_op == WB_PHASOR) begin
         c_in = nc_ff;
         s_in = sat_phase(acc_shr);
      end
      if (cmd.rn_op == RN_WRITE_C) begin
         c_in = div_result;
      end
      if (cmd.rn_op == RN_WRITE_S) begin
         s_in = div_result;
      end
      if (csr_write) begin
         case (csr_index)
            REG_ROTATE_EN: en_in = csr_wdata[0];
            REG_STEP_COS: begin
               sc_in = sat_step(csr_wdata);
               c_in  = ONE_Q;
               s_in  = '0;
            end
            REG_STEP_SIN: begin
               ss_in = sat_step(csr_wdata);
               c_in  = ONE_Q;
               s_in  = '0;
            end
            default: en_in = en_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0;
         sc_ff <= ONE_Q;
         ss_ff <= '0;
         c_ff  <= ONE_Q;
         s_ff  <= '0;
      end else begin
         en_ff <= en_in;
         sc_ff <= sc_in;
         ss_ff <= ss_in;
         c_ff  <= c_in;
         s_ff  <= s_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;

      case (cmd.acc_op)
         ACC_LOAD: acc_ff <= prod_ext;
         ACC_ADD:  acc_ff <= acc_ff + prod_ext;
         ACC_SUB:  acc_ff <= acc_ff - prod_ext;
         default:  acc_ff <= acc_ff;
      endcase

      if (cmd.load_req) begin
         r_ff     <= req_in_i;
         q_ff     <= req_in_q;
         last_ff  <= req_block_end;
         res_i_ff <= {req_in_i[SAMPLE_W-1], req_in_i};
         res_q_ff <= {req_in_q[SAMPLE_W-1], req_in_q};
      end

      case (cmd.wb_op)
         WB_OUT_I: res_i_ff <= sat_out(acc_shr);
         WB_OUT_Q: res_q_ff <= sat_out(acc_shr);
         WB_NEW_C: nc_ff    <= sat_phase(acc_shr);
         default:  nc_ff    <= nc_ff;
      endcase

      case (cmd.rn_op)
         RN_SQRT_INIT: begin
            sq_rem_ff  <= acc_ff[SQ_W-1:0];
            sq_root_ff <= '0;
            sq_bit_ff  <= SQ_W'(1) << (SQ_W - 2);
         end
         RN_SQRT_STEP: begin
            if (sq_rem_ff >= sq_trial) begin
               sq_rem_ff  <= sq_rem_ff - sq_trial;
               sq_root_ff <= (sq_root_ff >> 1) + sq_bit_ff;
            end else begin
               sq_root_ff <= sq_root_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         RN_MAG: mag_ff <= mag_value;
         RN_DIV_INIT_C, RN_DIV_INIT_S: begin
            div_q_ff   <= div_dvd;
            div_rem_ff <= '0;
            div_neg_ff <= div_src[PHASE_W-1];
         end
         RN_DIV_STEP: begin
            div_q_ff   <= {div_q_ff[DIV_W-2:0], div_ge};
            div_rem_ff <= div_ge ? div_sub[PHASE_W-1:0] : div_sh[PHASE_W-1:0];
         end
         default: mag_ff <= mag_ff;
      endcase

      if (cmd.publish) begin
         out_i_ff    <= res_i_ff;
         out_q_ff    <= res_q_ff;
         out_last_ff <= last_ff;
      end
   end

   assign status.rotate_en = en_ff;
   assign status.last      = last_ff;
   assign status.m2_zero   = (acc_ff == '0);

   assign rsp_out_i    = out_i_ff;
   assign rsp_out_q    = out_q_ff;
   assign rsp_out_last = out_last_ff;

endmodule
`default_nettype wire

/* src/complex_rotator_mixer.sv */
`timescale 1ns / 1ps
// a request that ends a block also runs the magnitude, square root and two
// divides that renormalise the phasor
// throughput: one request at a time; the next is taken in the cycle after the
// result is loaded, set by the single shared multiplier and bit-serial divider
// reset: synchronous active high; rotation off, step 1.0 + 0j, phasor 1.0 + 0j
`default_nettype none
// ----------------------------------------------------------------------------
// complex_rotator_mixer
// Frequency shifter for I/Q samples using a recursive oscillator phasor with
// per-block renormalisation to unit magnitude.
// ----------------------------------------------------------------------------
module complex_rotator_mixer
   import crm_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [PHASE_W-1:0]         csr_wdata,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [SAMPLE_W-1:0] req_in_i,
   input  wire logic signed [SAMPLE_W-1:0] req_in_q,
   input  wire logic                       req_block_end,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [OUT_W-1:0]         rsp_out_i,
   output logic signed [OUT_W-1:0]         rsp_out_q,
   output logic                            rsp_out_last
);

   crm_cmd_type    cmd;
   crm_status_type status;

   // register writes must only arrive while idle; the block itself does not enforce it
   assign csr_ready = 1'b1;

   crm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   crm_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_in_i      (req_in_i),
      .req_in_q      (req_in_q),
      .req_block_end (req_block_end),
      .cmd           (cmd),
      .status        (status),
      .rsp_out_i     (rsp_out_i),
      .rsp_out_q     (rsp_out_q),
      .rsp_out_last  (rsp_out_last)
   );

endmodule
`default_nettype wire

/* tb/tb_complex_rotator_mixer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_rotator_mixer
// Self-checking bench for the I/Q rotator: a bit-exact phasor predictor follows
// every accepted request and register write, and each response is compared
// field by field against the oldest prediction. Directed cases cover
// pass-through, step saturation, zero magnitude and output clipping; random
// traffic then runs under three idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_complex_rotator_mixer
   import crm_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 4000;
   // longest request: rotation, square root and two divides, with margin
   localparam int SETTLE_CYCLES  = 200;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   localparam longint UNIT       = longint'(1) <<< FRAC_BITS;
   localparam longint PHASOR_MAX = (longint'(1) <<< 31) - 1;
   localparam longint PHASOR_MIN = -(longint'(1) <<< 31);
   localparam longint OUT_HI     = 65535;
   localparam longint OUT_LO     = -65536;

   typedef struct {
      logic signed [OUT_W-1:0] out_i;
      logic signed [OUT_W-1:0] out_q;
      logic                    last;
   } mixed_sample_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [PHASE_W-1:0]         csr_wdata;
   logic                       req_valid;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_in_i;
   logic signed [SAMPLE_W-1:0] req_in_q;
   logic                       req_block_end;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [OUT_W-1:0]    rsp_out_i;
   logic signed [OUT_W-1:0]    rsp_out_q;
   logic                       rsp_out_last;

   // predictor state
   logic   rot_en;
   longint step_c;
   longint step_s;
   longint phasor_c;
   longint phasor_s;

   mixed_sample_type expected_samples[$];
   mixed_sample_type head;
   int               mismatches = 0;
   int               quiet_cycles = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;

   complex_rotator_mixer u_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_i      (req_in_i),
      .req_in_q      (req_in_q),
      .req_block_end (req_block_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_i     (rsp_out_i),
      .rsp_out_q     (rsp_out_q),
      .rsp_out_last  (rsp_out_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic longint clamp(input longint x, input longint lo, input longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
   endfunction

   // nearest, ties towards plus infinity
   function automatic longint round_q(input longint x);
      return (x + (UNIT >>> 1)) >>> FRAC_BITS;
   endfunction

   function automatic longint unsigned root_rounded(input longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      if (v - r * r > r) r++;
      return r;
   endfunction

   // nearest, ties away from zero
   function automatic longint div_nearest(input longint num, input longint unsigned den);
      longint unsigned mag_num;
      longint unsigned quo;
      if (num < 0) mag_num = -num;
      else mag_num = num;
      quo = (mag_num + den / 2) / den;
      if (num < 0) return -longint'(quo);
      return longint'(quo);
   endfunction

   function automatic void renormalise_phasor();
      longint unsigned mc;
      longint unsigned ms;
      longint unsigned m2;
      longint unsigned mag;
      if (phasor_c < 0) mc = -phasor_c;
      else mc = phasor_c;
      if (phasor_s < 0) ms = -phasor_s;
      else ms = phasor_s;
      m2 = mc * mc + ms * ms;
      if (m2 == 0) return;
      mag = root_rounded(m2);
      phasor_c = clamp(div_nearest(phasor_c * UNIT, mag), PHASOR_MIN, PHASOR_MAX);
      phasor_s = clamp(div_nearest(phasor_s * UNIT, mag), PHASOR_MIN, PHASOR_MAX);
   endfunction

   function automatic void model_reset();
      rot_en   = 1'b0;
      step_c   = UNIT;
      step_s   = 0;
      phasor_c = UNIT;
      phasor_s = 0;
   endfunction

   function automatic void model_csr_write(input logic [CSR_IDX_W-1:0] idx,
                                           input logic [PHASE_W-1:0] data);
      case (idx)
         REG_ROTATE_EN: rot_en = data[0];
         REG_STEP_COS: begin
            step_c   = clamp(longint'($signed(data)), -UNIT, UNIT);
            phasor_c = UNIT;
            phasor_s = 0;
         end
         REG_STEP_SIN: begin
            step_s   = clamp(longint'($signed(data)), -UNIT, UNIT);
            phasor_c = UNIT;
            phasor_s = 0;
         end
         default: ;
      endcase
   endfunction

   function automatic mixed_sample_type mix_sample(input logic signed [SAMPLE_W-1:0] si,
                                                   input logic signed [SAMPLE_W-1:0] sq,
                                                   input logic last);
      mixed_sample_type res;
      longint r;
      longint q;
      longint oi;
      longint oq;
      longint nc;
      longint ns;
      r = si;
      q = sq;
      if (rot_en) begin
         oi = clamp(round_q(r * phasor_c - q * phasor_s), OUT_LO, OUT_HI);
         oq = clamp(round_q(q * phasor_c + r * phasor_s), OUT_LO, OUT_HI);
         nc = round_q(phasor_c * step_c - phasor_s * step_s);
         ns = round_q(phasor_s * step_c + phasor_c * step_s);
         phasor_c = clamp(nc, PHASOR_MIN, PHASOR_MAX);
         phasor_s = clamp(ns, PHASOR_MIN, PHASOR_MAX);
      end else begin
         oi = r;
         oq = q;
      end
      // renormalisation runs on block end even with rotation off
      if (last) renormalise_phasor();
      res.out_i = oi[OUT_W-1:0];
      res.out_q = oq[OUT_W-1:0];
      res.last  = last;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected response i=%0d q=%0d last=%0b",
                     $time, rsp_out_i, rsp_out_q, rsp_out_last);
            mismatches++;
         end else begin
            head = expected_samples.pop_front();
            if (rsp_out_i !== head.out_i) begin
               $display("%0t: out_i expected %0d actual %0d", $time, head.out_i, rsp_out_i);
               mismatches++;
            end
            if (rsp_out_q !== head.out_q) begin
               $display("%0t: out_q expected %0d actual %0d", $time, head.out_q, rsp_out_q);
               mismatches++;
            end
            if (rsp_out_last !== head.last) begin
               $display("%0t: out_last expected %0b actual %0b",
                        $time, head.last, rsp_out_last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_complex_rotator_mixer failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   // valid is left high after acceptance so back-to-back requests need no drop
   task automatic send_sample(input logic [SAMPLE_W-1:0] i_word,
                              input logic [SAMPLE_W-1:0] q_word, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_in_i      <= i_word;
      req_in_q      <= q_word;
      req_block_end <= last;
      do @(posedge clock); while (!req_ready);
      expected_samples.push_back(mix_sample($signed(i_word), $signed(q_word), last));
   endtask

   task automatic stop_requests();
      req_valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (expected_samples.size() != 0) @(posedge clock);
   endtask

   // quiet spell on both channels before register writes
   task automatic quiesce();
      stop_requests();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [PHASE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      model_csr_write(idx, data);
   endtask

   task automatic apply_setting(input logic [PHASE_W-1:0] en_word,
                                input logic [PHASE_W-1:0] cos_word,
                                input logic [PHASE_W-1:0] sin_word);
      quiesce();
      write_csr(REG_ROTATE_EN, en_word);
      if ($urandom_range(1)) begin
         write_csr(REG_STEP_COS, cos_word);
         write_csr(REG_STEP_SIN, sin_word);
      end else begin
         write_csr(REG_STEP_SIN, sin_word);
         write_csr(REG_STEP_COS, cos_word);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [PHASE_W-1:0] extreme_step_word();
      case ($urandom_range(4))
         0: return ONE_Q;
         1: return NEG_ONE_Q;
         2: return '0;
         3: return 32'h7FFF_FFFF;
         default: return 32'h8000_0000;
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      if ($urandom_range(99) < 10) begin
         case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'hFFFF;
         endcase
      end
      return SAMPLE_W'($urandom());
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_passthrough();
      // registers still at their reset values
      send_sample(16'h8000, 16'h7FFF, 1'b0);
      send_sample(16'h7FFF, 16'h8000, 1'b0);
      send_sample(16'h0000, 16'h0000, 1'b0);
      send_sample(16'hFFFF, 16'h0001, 1'b1);
   endtask

   task automatic test_quarter_turn();
      apply_setting(32'd1, '0, ONE_Q);
      send_sample(16'h7FFF, 16'h8000, 1'b0);
      send_sample(16'h8000, 16'h8000, 1'b0);
      send_sample(16'h7FFF, 16'h7FFF, 1'b0);
      send_sample(16'h8000, 16'h7FFF, 1'b1);
   endtask

   task automatic test_step_saturation();
      // both steps beyond unit range, clipped on write
      apply_setting(32'd1, 32'h7FFF_FFFF, 32'h8000_0000);
      send_sample(16'h4000, 16'hC000, 1'b0);
      send_sample(16'h7FFF, 16'h0001, 1'b0);
      send_sample(16'h1234, 16'h8000, 1'b1);
   endtask

   task automatic test_zero_magnitude();
      // phasor collapses to zero after one request and renormalisation leaves it
      apply_setting(32'd1, '0, '0);
      send_sample(16'h7FFF, 16'h8000, 1'b0);
      send_sample(16'h7FFF, 16'h7FFF, 1'b1);
      send_sample(16'h8000, 16'h8000, 1'b0);
   endtask

   task automatic test_output_saturation();
      // step magnitude above one, phasor grows until it clips
      apply_setting(32'd1, ONE_Q, ONE_Q);
      send_sample(16'h7FFF, 16'h8000, 1'b0);
      send_sample(16'h8000, 16'h7FFF, 1'b0);
      send_sample(16'h7FFF, 16'h8000, 1'b0);
      send_sample(16'h8000, 16'h7FFF, 1'b0);
      send_sample(16'h8000, 16'h8000, 1'b0);
      send_sample(16'h7FFF, 16'h7FFF, 1'b1);
   endtask

   task automatic test_enable_hold();
      apply_setting(32'd1, '0, NEG_ONE_Q);
      send_sample(16'h2000, 16'h1000, 1'b0);
      send_sample(16'hE000, 16'h7FFF, 1'b0);
      // enable write alone keeps the phasor, unused index is ignored
      quiesce();
      write_csr(REG_ROTATE_EN, 32'd0);
      write_csr(REG_UNUSED, 32'hFFFF_FFFF);
      csr_valid <= 1'b0;
      send_sample(16'h8000, 16'h7FFF, 1'b0);
      quiesce();
      write_csr(REG_ROTATE_EN, 32'hFFFF_FFFF);
      csr_valid <= 1'b0;
      send_sample(16'h3000, 16'hD000, 1'b1);
   endtask

   task automatic test_random_traffic(input int n_items);
      int     sent;
      int     seg_left;
      int     blen;
      logic   noisy;
      logic   last;
      real    ang;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(9))
            0: apply_setting(32'd0, $urandom(), $urandom());
            1: apply_setting(32'd1, extreme_step_word(), extreme_step_word());
            2: apply_setting($urandom(), $urandom(), $urandom());
            3: begin
               quiesce();
               write_csr(REG_ROTATE_EN, $urandom());
               if ($urandom_range(1)) write_csr(REG_UNUSED, $urandom());
               csr_valid <= 1'b0;
            end
            default: begin
               ang = $urandom_range(1000000) * 6.283185307179586 / 1.0e6;
               apply_setting(32'd1, PHASE_W'($rtoi($cos(ang) * 1073741824.0)),
                             PHASE_W'($rtoi($sin(ang) * 1073741824.0)));
            end
         endcase
         seg_left = $urandom_range(20, 80);
         while (seg_left > 0 && sent < n_items) begin
            noisy = ($urandom_range(99) < 15);
            blen  = $urandom_range(1, 16);
            for (int k = 0; k < blen; k++) begin
               last = noisy ? 1'($urandom_range(1)) : (k == blen - 1);
               send_sample(pick_sample(), pick_sample(), last);
            end
            sent     += blen;
            seg_left -= blen;
            // now and then hold off until the pipeline is empty
            if ($urandom_range(99) < 3) begin
               stop_requests();
               wait_for_results();
            end
         end
      end
   endtask

   initial begin
      model_reset();
      reset         = 1'b1;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      req_valid     = 1'b0;
      req_in_i      = '0;
      req_in_q      = '0;
      req_block_end = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 37;
      recv_idle_pct = 82;
      test_passthrough();
      test_quarter_turn();
      test_step_saturation();
      test_zero_magnitude();
      test_output_saturation();
      test_enable_hold();
      test_random_traffic(340);

      send_idle_pct = 82;
      recv_idle_pct = 37;
      test_random_traffic(340);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(340);

      quiesce();
      if (mismatches == 0) begin
         $display("tb_complex_rotator_mixer passed");
      end else begin
         $display("tb_complex_rotator_mixer failed");
      end
      $finish;
   end

endmodule
